>>> hdl/sit_pkg.sv
// Shared constants and query codes for the sphere intersection tests.
package sit_pkg;

    localparam int DEF_COORD_WIDTH  = 16;
    localparam int DEF_RADIUS_WIDTH = 16;

    typedef enum logic [1:0] {
        MODE_SPHERE  = 2'd0,
        MODE_BOX     = 2'd1,
        MODE_SEGMENT = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

endpackage

>>> hdl/sit_front.sv
// Front pipeline: differences and box clamp, products, sums (three stages).
module sit_front #(
    parameter int COORD_WIDTH  = sit_pkg::DEF_COORD_WIDTH,
    parameter int RADIUS_WIDTH = sit_pkg::DEF_RADIUS_WIDTH,
    localparam int DW  = COORD_WIDTH + 1,
    localparam int PW  = 2 * DW,
    localparam int SW  = PW + 2,
    localparam int XW  = PW + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sit_pkg::mode_t                 mode,
    input  logic signed [COORD_WIDTH-1:0]  center [3],
    input  logic signed [COORD_WIDTH-1:0]  first [3],
    input  logic signed [COORD_WIDTH-1:0]  second [3],
    input  logic [RADIUS_WIDTH-1:0]        sphere_radius,
    input  logic [RADIUS_WIDTH-1:0]        other_radius,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sit_pkg::mode_t                 out_mode,
    output logic signed [SW-1:0]           nv,
    output logic signed [SW-1:0]           ne,
    output logic signed [SW-1:0]           nb,
    output logic signed [SW-1:0]           tdot,
    output logic signed [SW-1:0]           len,
    output logic signed [XW-1:0]           cross_term [3],
    output logic [2*RADIUS_WIDTH-1:0]      rr,
    output logic [2*RADIUS_WIDTH+1:0]      ss
);

    logic vld1_reg, vld2_reg, vld3_reg;
    logic en1, en2, en3;

    // stage 1
    sit_pkg::mode_t          mode1_reg;
    logic signed [DW-1:0]    v_reg [3];
    logic signed [DW-1:0]    d_reg [3];
    logic signed [DW-1:0]    e_reg [3];
    logic signed [DW-1:0]    b_reg [3];
    logic signed [DW-1:0]    v_next [3];
    logic signed [DW-1:0]    d_next [3];
    logic signed [DW-1:0]    e_next [3];
    logic signed [DW-1:0]    b_next [3];
    logic signed [COORD_WIDTH-1:0] k_lo [3];
    logic signed [COORD_WIDTH-1:0] k_cl [3];
    logic [RADIUS_WIDTH-1:0] r1_reg;
    logic [RADIUS_WIDTH:0]   rs1_reg;

    // stage 2
    sit_pkg::mode_t          mode2_reg;
    logic signed [PW-1:0]    vv_reg [3];
    logic signed [PW-1:0]    ee_reg [3];
    logic signed [PW-1:0]    bb_reg [3];
    logic signed [PW-1:0]    vd_reg [3];
    logic signed [PW-1:0]    dd_reg [3];
    logic signed [PW-1:0]    xa_reg [3];
    logic signed [PW-1:0]    xb_reg [3];
    logic [2*RADIUS_WIDTH-1:0] rr2_reg;
    logic [2*RADIUS_WIDTH+1:0] ss2_reg;

    // stage 3
    sit_pkg::mode_t          mode3_reg;
    logic signed [SW-1:0]    nv_reg, ne_reg, nb_reg, t_reg, len_reg;
    logic signed [XW-1:0]    cr_reg [3];
    logic [2*RADIUS_WIDTH-1:0] rr3_reg;
    logic [2*RADIUS_WIDTH+1:0] ss3_reg;

    assign en3      = !vld3_reg || out_ready;
    assign en2      = !vld2_reg || en3;
    assign en1      = !vld1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_next[i] = DW'(center[i]) - DW'(first[i]);
            d_next[i] = DW'(second[i]) - DW'(first[i]);
            e_next[i] = DW'(center[i]) - DW'(second[i]);
            // raise to the minimum, then lower to the maximum
            k_lo[i]   = (center[i] < first[i]) ? first[i] : center[i];
            k_cl[i]   = (k_lo[i] > second[i]) ? second[i] : k_lo[i];
            b_next[i] = DW'(center[i]) - DW'(k_cl[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            if (en1) vld1_reg <= in_valid;
            if (en2) vld2_reg <= vld1_reg;
            if (en3) vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= mode;
            v_reg     <= v_next;
            d_reg     <= d_next;
            e_reg     <= e_next;
            b_reg     <= b_next;
            r1_reg    <= sphere_radius;
            rs1_reg   <= (RADIUS_WIDTH+1)'(sphere_radius) + (RADIUS_WIDTH+1)'(other_radius);
        end
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            for (int i = 0; i < 3; i++)
            begin
                vv_reg[i] <= v_reg[i] * v_reg[i];
                ee_reg[i] <= e_reg[i] * e_reg[i];
                bb_reg[i] <= b_reg[i] * b_reg[i];
                vd_reg[i] <= v_reg[i] * d_reg[i];
                dd_reg[i] <= d_reg[i] * d_reg[i];
            end
            xa_reg[0] <= v_reg[1] * d_reg[2];
            xb_reg[0] <= v_reg[2] * d_reg[1];
            xa_reg[1] <= v_reg[2] * d_reg[0];
            xb_reg[1] <= v_reg[0] * d_reg[2];
            xa_reg[2] <= v_reg[0] * d_reg[1];
            xb_reg[2] <= v_reg[1] * d_reg[0];
            rr2_reg   <= (2*RADIUS_WIDTH)'(r1_reg) * (2*RADIUS_WIDTH)'(r1_reg);
            ss2_reg   <= (2*RADIUS_WIDTH+2)'(rs1_reg) * (2*RADIUS_WIDTH+2)'(rs1_reg);
        end
        if (en3)
        begin
            mode3_reg <= mode2_reg;
            nv_reg  <= SW'(vv_reg[0]) + SW'(vv_reg[1]) + SW'(vv_reg[2]);
            ne_reg  <= SW'(ee_reg[0]) + SW'(ee_reg[1]) + SW'(ee_reg[2]);
            nb_reg  <= SW'(bb_reg[0]) + SW'(bb_reg[1]) + SW'(bb_reg[2]);
            t_reg   <= SW'(vd_reg[0]) + SW'(vd_reg[1]) + SW'(vd_reg[2]);
            len_reg <= SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
            for (int i = 0; i < 3; i++)
                cr_reg[i] <= XW'(xa_reg[i]) - XW'(xb_reg[i]);
            rr3_reg <= rr2_reg;
            ss3_reg <= ss2_reg;
        end
    end

    assign out_valid  = vld3_reg;
    assign out_mode   = mode3_reg;
    assign nv         = nv_reg;
    assign ne         = ne_reg;
    assign nb         = nb_reg;
    assign tdot       = t_reg;
    assign len        = len_reg;
    assign cross_term = cr_reg;
    assign rr         = rr3_reg;
    assign ss         = ss3_reg;

endmodule

>>> hdl/sit_tail.sv
// Back pipeline: comparisons, split cross-term squares, final decision (five stages).
module sit_tail #(
    parameter int COORD_WIDTH  = sit_pkg::DEF_COORD_WIDTH,
    parameter int RADIUS_WIDTH = sit_pkg::DEF_RADIUS_WIDTH,
    localparam int DW   = COORD_WIDTH + 1,
    localparam int PW   = 2 * DW,
    localparam int SW   = PW + 2,
    localparam int XW   = PW + 1,
    localparam int RRW  = 2 * RADIUS_WIDTH,
    localparam int AW   = XW,
    localparam int LO   = AW / 2,
    localparam int HI   = AW - LO,
    localparam int SQW  = 2 * AW,
    localparam int SUMW = SQW + 2,
    localparam int LW   = PW + 1,
    localparam int LL   = LW / 2,
    localparam int LH   = LW - LL,
    localparam int RHW  = RRW + LW,
    localparam int CMPW = ((SUMW > RHW) ? SUMW : RHW) + 1,
    localparam int QW   = ((SW > RRW + 2) ? SW : RRW + 2) + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sit_pkg::mode_t         mode,
    input  logic signed [SW-1:0]   nv,
    input  logic signed [SW-1:0]   ne,
    input  logic signed [SW-1:0]   nb,
    input  logic signed [SW-1:0]   tdot,
    input  logic signed [SW-1:0]   len,
    input  logic signed [XW-1:0]   cross_term [3],
    input  logic [RRW-1:0]         rr,
    input  logic [RRW+1:0]         ss,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit
);

    logic vld4_reg, vld5_reg, vld6_reg, vld7_reg, vld8_reg;
    logic en4, en5, en6, en7, en8;

    // stage 4: decide the easy cases, take magnitudes
    logic              known_next, khit_next;
    logic [QW-1:0]     q_nv, q_ne, q_nb, q_rr, q_ss;
    logic              known4_reg, khit4_reg;
    logic [AW-1:0]     mag4_reg [3];
    logic [AW-1:0]     mag_next [3];
    logic [RRW-1:0]    rr4_reg;
    logic [LW-1:0]     len4_reg;

    // stage 5: partial products
    logic              known5_reg, khit5_reg;
    logic [2*LO-1:0]   ll5_reg [3];
    logic [LO+HI-1:0]  lh5_reg [3];
    logic [2*HI-1:0]   hh5_reg [3];
    logic [RRW+LL-1:0] rl5_reg;
    logic [RRW+LH-1:0] rh5_reg;

    // stage 6: squares and right-hand side
    logic              known6_reg, khit6_reg;
    logic [SQW-1:0]    sq6_reg [3];
    logic [RHW-1:0]    rhs6_reg;

    // stage 7: sum of squares
    logic              known7_reg, khit7_reg;
    logic [SUMW-1:0]   cr7_reg;
    logic [RHW-1:0]    rhs7_reg;

    // stage 8: output register
    logic              hit8_reg;

    assign en8      = !vld8_reg || out_ready;
    assign en7      = !vld7_reg || en8;
    assign en6      = !vld6_reg || en7;
    assign en5      = !vld5_reg || en6;
    assign en4      = !vld4_reg || en5;
    assign in_ready = en4;

    always_comb
    begin
        // all squared norms are non-negative, so a zero-extended compare works
        q_nv = QW'(nv);
        q_ne = QW'(ne);
        q_nb = QW'(nb);
        q_rr = QW'(rr);
        q_ss = QW'(ss);
        known_next = 1'b1;
        khit_next  = 1'b0;
        unique case (mode)
            sit_pkg::MODE_SPHERE:
                khit_next = (q_nv <= q_ss);
            sit_pkg::MODE_BOX:
                khit_next = (q_nb <= q_rr);
            sit_pkg::MODE_SEGMENT:
            begin
                if (tdot <= SW'(0))
                    khit_next = (q_nv <= q_rr);
                else if (len <= tdot)
                    khit_next = (q_ne <= q_rr);
                else
                    known_next = 1'b0;
            end
            sit_pkg::MODE_NONE:
                khit_next = 1'b0;
            default:
                khit_next = 1'b0;
        endcase
        for (int i = 0; i < 3; i++)
            mag_next[i] = cross_term[i][XW-1] ? AW'(-cross_term[i]) : AW'(cross_term[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
        end
        else
        begin
            if (en4) vld4_reg <= in_valid;
            if (en5) vld5_reg <= vld4_reg;
            if (en6) vld6_reg <= vld5_reg;
            if (en7) vld7_reg <= vld6_reg;
            if (en8) vld8_reg <= vld7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            known4_reg <= known_next;
            khit4_reg  <= khit_next;
            mag4_reg   <= mag_next;
            rr4_reg    <= rr;
            len4_reg   <= len[LW-1:0];
        end
        if (en5)
        begin
            known5_reg <= known4_reg;
            khit5_reg  <= khit4_reg;
            for (int i = 0; i < 3; i++)
            begin
                ll5_reg[i] <= (2*LO)'(mag4_reg[i][LO-1:0]) * (2*LO)'(mag4_reg[i][LO-1:0]);
                lh5_reg[i] <= (LO+HI)'(mag4_reg[i][LO-1:0]) * (LO+HI)'(mag4_reg[i][AW-1:LO]);
                hh5_reg[i] <= (2*HI)'(mag4_reg[i][AW-1:LO]) * (2*HI)'(mag4_reg[i][AW-1:LO]);
            end
            rl5_reg <= (RRW+LL)'(rr4_reg) * (RRW+LL)'(len4_reg[LL-1:0]);
            rh5_reg <= (RRW+LH)'(rr4_reg) * (RRW+LH)'(len4_reg[LW-1:LL]);
        end
        if (en6)
        begin
            known6_reg <= known5_reg;
            khit6_reg  <= khit5_reg;
            for (int i = 0; i < 3; i++)
                sq6_reg[i] <= SQW'(ll5_reg[i]) + (SQW'(lh5_reg[i]) << (LO + 1))
                              + (SQW'(hh5_reg[i]) << (2 * LO));
            rhs6_reg <= RHW'(rl5_reg) + (RHW'(rh5_reg) << LL);
        end
        if (en7)
        begin
            known7_reg <= known6_reg;
            khit7_reg  <= khit6_reg;
            cr7_reg    <= SUMW'(sq6_reg[0]) + SUMW'(sq6_reg[1]) + SUMW'(sq6_reg[2]);
            rhs7_reg   <= rhs6_reg;
        end
        if (en8)
            hit8_reg <= known7_reg ? khit7_reg : (CMPW'(cr7_reg) <= CMPW'(rhs7_reg));
    end

    assign out_valid = vld8_reg;
    assign hit       = hit8_reg;

endmodule

>>> hdl/sphere_intersection_tests_top.sv
// Top level of the sphere intersection test pipeline.
//
// Usage: each transfer on the s_ stream carries one query: a sphere (center,
// radius) and a second primitive selected by s_tuser (0 sphere, 1 axis-aligned
// box, 2 line segment, 3 gives no hit). Every query yields exactly one
// transfer on the m_ stream with the hit flag in m_tdata bit 0.
// All tests are exact integer compares, inclusive, with no division.
//
// Throughput: one query per cycle while m_tready is high; set by the 8-stage
// pipeline, where each stage holds one multiplier layer or one adder/compare
// layer. The stages are: differences and box clamp, products, sums, compares
// and magnitudes, split partial products of the cross term, squares, sum of
// squares, final decision in the output register.
//
// Reset clears all stage valid bits; the pipeline is empty and ready.
// When the receiver holds m_tready low, each stage holds its data until the
// stage ahead frees up; bubbles collapse, so s_tready only drops once every
// stage holds a query. Nothing is lost or repeated under stalls.
module sphere_intersection_tests_top #(
    parameter int COORD_WIDTH  = sit_pkg::DEF_COORD_WIDTH,
    parameter int RADIUS_WIDTH = sit_pkg::DEF_RADIUS_WIDTH,
    localparam int IN_BITS = 9 * COORD_WIDTH + 2 * RADIUS_WIDTH,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // center_x, center_y, center_z, sphere_radius, first_x, first_y, first_z,
    // second_x, second_y, second_z, other_radius, zero fill
    input  logic [IN_W-1:0] s_tdata,
    // mode
    input  logic [1:0]      s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    // hit, zero fill
    output logic [7:0]      m_tdata
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 2;
    localparam int XW  = PW + 1;
    localparam int CW  = COORD_WIDTH;
    localparam int RW  = RADIUS_WIDTH;
    localparam int OFS_C  = 0;
    localparam int OFS_R  = 3 * CW;
    localparam int OFS_F  = OFS_R + RW;
    localparam int OFS_S  = OFS_F + 3 * CW;
    localparam int OFS_OR = OFS_S + 3 * CW;

    logic signed [CW-1:0] center [3];
    logic signed [CW-1:0] first  [3];
    logic signed [CW-1:0] second [3];
    logic [RW-1:0]        sphere_radius;
    logic [RW-1:0]        other_radius;
    sit_pkg::mode_t       mode;

    logic                 mid_valid, mid_ready;
    sit_pkg::mode_t       mid_mode;
    logic signed [SW-1:0] mid_nv, mid_ne, mid_nb, mid_t, mid_len;
    logic signed [XW-1:0] mid_cross [3];
    logic [2*RW-1:0]      mid_rr;
    logic [2*RW+1:0]      mid_ss;
    logic                 hit;

    // unpack the query fields
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            center[i] = s_tdata[OFS_C + i*CW +: CW];
            first[i]  = s_tdata[OFS_F + i*CW +: CW];
            second[i] = s_tdata[OFS_S + i*CW +: CW];
        end
        sphere_radius = s_tdata[OFS_R +: RW];
        other_radius  = s_tdata[OFS_OR +: RW];
        mode          = sit_pkg::mode_t'(s_tuser);
    end

    sit_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .mode          (mode),
        .center        (center),
        .first         (first),
        .second        (second),
        .sphere_radius (sphere_radius),
        .other_radius  (other_radius),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_mode      (mid_mode),
        .nv            (mid_nv),
        .ne            (mid_ne),
        .nb            (mid_nb),
        .tdot          (mid_t),
        .len           (mid_len),
        .cross_term    (mid_cross),
        .rr            (mid_rr),
        .ss            (mid_ss)
    );

    sit_tail #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_tail (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .mode       (mid_mode),
        .nv         (mid_nv),
        .ne         (mid_ne),
        .nb         (mid_nb),
        .tdot       (mid_t),
        .len        (mid_len),
        .cross_term (mid_cross),
        .rr         (mid_rr),
        .ss         (mid_ss),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .hit        (hit)
    );

    assign m_tdata = {7'b0, hit};

endmodule
